// ----- design/rlcm_pkg.sv -----
package rlcm_pkg;

  localparam int OFF_W = 48;
  localparam int CNT_W = 13;
  localparam int SLOT_W = 4;
  localparam int IDX_W = 12;
  localparam int KIND_W = 3;
  localparam int STAMP_W = 32;
  localparam int EXT_W = 50;
  localparam logic [CNT_W-1:0] BUF_MAX = 13'h1FFF;

  typedef enum logic [0:0] {
    OP_LOOKUP = 1'b0,
    OP_COMMIT = 1'b1
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_COPY   = 3'd0,
    KIND_HIT    = 3'd1,
    KIND_NEW    = 3'd2,
    KIND_FULL   = 3'd3,
    KIND_COMMIT = 3'd4
  } kind_t;

  typedef struct packed {
    logic [OFF_W-1:0]   base;
    logic               committed;
    logic [CNT_W-1:0]   buffered;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] source_slot;
    logic [IDX_W-1:0]  source_index;
    logic [IDX_W-1:0]  dest_index;
    logic [CNT_W-1:0]  copy_length;
    logic [CNT_W-1:0]  prefilled_bytes;
    logic [OFF_W-1:0]  unfilled_start;
    logic [OFF_W-1:0]  unfilled_end;
    logic              last;
  } res_t;

endpackage

// ----- design/rlcm_if.sv -----
interface rlcm_req_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [rlcm_pkg::OFF_W-1:0]  byte_offset;
  logic [rlcm_pkg::CNT_W-1:0]  byte_count;
  logic [rlcm_pkg::SLOT_W-1:0] line_slot;

  modport source(output valid, opcode, byte_offset, byte_count, line_slot, input ready);
  modport sink(input valid, opcode, byte_offset, byte_count, line_slot, output ready);
endinterface

interface rlcm_res_if;
  logic                        valid;
  logic                        ready;
  logic [rlcm_pkg::KIND_W-1:0] kind;
  logic [rlcm_pkg::SLOT_W-1:0] slot;
  logic [rlcm_pkg::SLOT_W-1:0] source_slot;
  logic [rlcm_pkg::IDX_W-1:0]  source_index;
  logic [rlcm_pkg::IDX_W-1:0]  dest_index;
  logic [rlcm_pkg::CNT_W-1:0]  copy_length;
  logic [rlcm_pkg::CNT_W-1:0]  prefilled_bytes;
  logic [rlcm_pkg::OFF_W-1:0]  unfilled_start;
  logic [rlcm_pkg::OFF_W-1:0]  unfilled_end;
  logic                        last;

  modport source(output valid, kind, slot, source_slot, source_index, dest_index,
                 copy_length, prefilled_bytes, unfilled_start, unfilled_end, last,
                 input ready);
  modport sink(input valid, kind, slot, source_slot, source_index, dest_index,
               copy_length, prefilled_bytes, unfilled_start, unfilled_end, last,
               output ready);
endinterface

// ----- design/rlcm_ram.sv -----
module rlcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/range_line_cache_manager_unit.sv -----
// Metadata manager for a cache of MAX_LINES lines of LINE_BYTES bytes each. One request
// is handled at a time. A commit reads its line from the line memory, then writes it back,
// if the slot holds a valid line, as it hands off its result. A lookup reads every slot
// from the line memory once, one slot per cycle; a reservation that finds an overlapping
// line reads every slot a second time to find the next overlap, and a second copy may
// follow. The line memory has a single read port. Results leave through an output
// register, up to three per request, the last one flagged by last.
module range_line_cache_manager_unit #(
  parameter int LINE_BYTES = 4096,
  parameter int MAX_LINES = 16
) (
  input logic clk,
  input logic rst,
  rlcm_req_if.sink req,
  rlcm_res_if.source res
);
  import rlcm_pkg::*;

  localparam int SW = $clog2(MAX_LINES);
  localparam int CW = $clog2(MAX_LINES + 1);
  localparam logic [EXT_W-1:0] LINE_X = EXT_W'(LINE_BYTES);
  localparam logic [CW-1:0] NLINES = CW'(MAX_LINES);
  localparam logic [8:0] NLINES9 = 9'(MAX_LINES);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CRD   = 8'b0000_0010,
    S_CWR   = 8'b0000_0100,
    S_SCAN1 = 8'b0000_1000,
    S_DEC   = 8'b0001_0000,
    S_SCAN2 = 8'b0010_0000,
    S_CP2   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state;
  logic [MAX_LINES-1:0] line_valid;
  logic [STAMP_W-1:0] stamp;
  logic [OFF_W-1:0] off;
  logic [CNT_W-1:0] cnt;
  logic [SLOT_W-1:0] ls;
  logic [EXT_W-1:0] us, ue;
  logic [CW-1:0] scan_idx, nvalid;
  logic pend;
  logic [SW-1:0] pend_idx;
  logic hit_f, same_f, vic_f, free_f, c1_f, c2_f, full_r;
  logic [SW-1:0] hit_slot, same_slot, vic_slot, free_slot, c1_slot, c2_slot, dest;
  logic [OFF_W-1:0] hit_base, vic_base, c1_base, c2_base;
  logic [STAMP_W-1:0] vic_age;
  res_t o_res;
  logic o_valid;

  logic ram_we, ram_re;
  logic [SW-1:0] ram_waddr, ram_raddr;
  line_t ram_wdata, e;

  rlcm_ram #(.WIDTH($bits(line_t)), .DEPTH(MAX_LINES)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(e)
  );

  logic out_free, ev, ov, full, ls_ok;
  logic [SW-1:0] ls_addr, dest_c;
  logic [EXT_W-1:0] off_x, base_x, end_x, es, ee, os, oe, cuse, pre;
  logic [STAMP_W-1:0] age;
  logic [CNT_W:0] bsum;

  always_comb begin
    out_free = !o_valid || res.ready;
    ev = line_valid[pend_idx];
    off_x = EXT_W'(off);
    base_x = EXT_W'(e.base);
    end_x = base_x + LINE_X;
    ov = (base_x < ue) && (us < end_x);
    age = stamp - e.stamp;
    full = (nvalid >= NLINES);
    ls_ok = 9'(ls) < NLINES9;
    ls_addr = SW'(ls);
    dest_c = same_f ? same_slot : (full ? vic_slot : free_slot);
    es = (state == S_DEC) ? EXT_W'(c1_base) : EXT_W'(c2_base);
    ee = es + LINE_X;
    os = (es > us) ? es : us;
    oe = (ee < ue) ? ee : ue;
    cuse = oe - os;
    pre = LINE_X - (ue - us);
    bsum = {1'b0, e.buffered} + {1'b0, cnt};
    ram_re = 1'b0;
    ram_raddr = scan_idx[SW-1:0];
    if (state == S_CRD) begin
      ram_re = 1'b1;
      ram_raddr = ls_addr;
    end else if ((state == S_SCAN1 || state == S_SCAN2) && scan_idx < NLINES) begin
      ram_re = 1'b1;
    end
    ram_we = 1'b0;
    ram_waddr = dest;
    ram_wdata = '0;
    if (state == S_CWR && out_free && ls_ok && line_valid[ls_addr]) begin
      ram_we = 1'b1;
      ram_waddr = ls_addr;
      ram_wdata = e;
      ram_wdata.buffered = bsum[CNT_W] ? BUF_MAX : bsum[CNT_W-1:0];
      ram_wdata.committed = 1'b1;
      ram_wdata.stamp = stamp;
    end else if (state == S_FIN && out_free) begin
      ram_we = 1'b1;
      ram_wdata.base = off;
      ram_wdata.buffered = (pre > EXT_W'(BUF_MAX)) ? BUF_MAX : pre[CNT_W-1:0];
    end
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      line_valid <= '0;
      stamp <= '0;
      o_valid <= 1'b0;
      pend <= 1'b0;
    end else begin
      if (out_free) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            off <= req.byte_offset;
            cnt <= req.byte_count;
            ls <= req.line_slot;
            us <= EXT_W'(req.byte_offset);
            ue <= EXT_W'(req.byte_offset) + LINE_X;
            scan_idx <= '0;
            nvalid <= '0;
            pend <= 1'b0;
            {hit_f, same_f, vic_f, free_f, c1_f, c2_f} <= '0;
            state <= (req.opcode == OP_COMMIT) ? S_CRD : S_SCAN1;
          end
        end
        S_CRD: begin
          state <= S_CWR;
        end
        S_CWR: begin
          if (out_free) begin
            if (ls_ok && line_valid[ls_addr]) begin
              stamp <= stamp + 1'b1;
            end
            o_res <= '0;
            o_res.kind <= KIND_COMMIT;
            o_res.slot <= ls;
            o_res.last <= 1'b1;
            o_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SCAN1, S_SCAN2: begin
          if (pend && ev) begin
            if (state == S_SCAN1) begin
              nvalid <= nvalid + 1'b1;
              if (e.base == off) begin
                same_f <= 1'b1;
                same_slot <= pend_idx;
              end
              if (off_x >= base_x && off_x + EXT_W'(cnt) < end_x &&
                  (!hit_f || e.base < hit_base)) begin
                hit_f <= 1'b1;
                hit_slot <= pend_idx;
                hit_base <= e.base;
              end
              if (e.committed && (!vic_f || age > vic_age ||
                  (age == vic_age && e.base < vic_base))) begin
                vic_f <= 1'b1;
                vic_slot <= pend_idx;
                vic_age <= age;
                vic_base <= e.base;
              end
              if (ov && (!c1_f || e.base < c1_base)) begin
                c1_f <= 1'b1;
                c1_slot <= pend_idx;
                c1_base <= e.base;
              end
            end else if (ov && e.base > c1_base && (!c2_f || e.base < c2_base)) begin
              c2_f <= 1'b1;
              c2_slot <= pend_idx;
              c2_base <= e.base;
            end
          end
          if (pend && !ev && state == S_SCAN1 && !free_f) begin
            free_f <= 1'b1;
            free_slot <= pend_idx;
          end
          if (scan_idx < NLINES) begin
            pend <= 1'b1;
            pend_idx <= scan_idx[SW-1:0];
            scan_idx <= scan_idx + 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              if (state == S_SCAN1) begin
                state <= S_DEC;
              end else begin
                state <= c2_f ? S_CP2 : S_FIN;
              end
            end
          end
        end
        S_DEC: begin
          if (out_free) begin
            full_r <= full;
            dest <= dest_c;
            o_res <= '0;
            if (hit_f) begin
              o_res.kind <= KIND_HIT;
              o_res.slot <= SLOT_W'(hit_slot);
              o_res.last <= 1'b1;
              o_valid <= 1'b1;
              state <= S_IDLE;
            end else if (full && !vic_f) begin
              o_res.kind <= KIND_FULL;
              o_res.last <= 1'b1;
              o_valid <= 1'b1;
              state <= S_IDLE;
            end else if (c1_f) begin
              o_res.kind <= KIND_COPY;
              o_res.slot <= SLOT_W'(dest_c);
              o_res.source_slot <= SLOT_W'(c1_slot);
              o_res.source_index <= IDX_W'(os - es);
              o_res.dest_index <= IDX_W'(os - off_x);
              o_res.copy_length <= CNT_W'(cuse);
              o_valid <= 1'b1;
              if (os == us) begin
                us <= us + cuse;
              end else begin
                ue <= ue - cuse;
              end
              scan_idx <= '0;
              state <= S_SCAN2;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_CP2: begin
          if (out_free) begin
            o_res <= '0;
            o_res.kind <= KIND_COPY;
            o_res.slot <= SLOT_W'(dest);
            o_res.source_slot <= SLOT_W'(c2_slot);
            o_res.source_index <= IDX_W'(os - es);
            o_res.dest_index <= IDX_W'(os - off_x);
            o_res.copy_length <= CNT_W'(cuse);
            o_valid <= 1'b1;
            if (os == us) begin
              us <= us + cuse;
            end else begin
              ue <= ue - cuse;
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            line_valid <= (line_valid & ~(MAX_LINES'(full_r) << vic_slot)) |
                          (MAX_LINES'(1) << dest);
            o_res <= '0;
            o_res.kind <= KIND_NEW;
            o_res.slot <= SLOT_W'(dest);
            o_res.prefilled_bytes <= CNT_W'(pre);
            o_res.unfilled_start <= OFF_W'(us);
            o_res.unfilled_end <= OFF_W'(ue);
            o_res.last <= 1'b1;
            o_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid = o_valid;
  assign res.kind = o_res.kind;
  assign res.slot = o_res.slot;
  assign res.source_slot = o_res.source_slot;
  assign res.source_index = o_res.source_index;
  assign res.dest_index = o_res.dest_index;
  assign res.copy_length = o_res.copy_length;
  assign res.prefilled_bytes = o_res.prefilled_bytes;
  assign res.unfilled_start = o_res.unfilled_start;
  assign res.unfilled_end = o_res.unfilled_end;
  assign res.last = o_res.last;

`ifndef SYNTHESIS
  a_stamp_on_commit: assert property (@(posedge clk) disable iff (rst)
    (stamp != $past(stamp)) |-> $past(state == S_CWR))
    else $error("stamp counter moved outside a commit");
  a_second_scan_needs_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN2) |-> c1_f)
    else $error("second scan without a first overlap");
  a_reserve_marks_dest: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> line_valid[$past(dest)])
    else $error("reserved line not marked valid");
`endif

endmodule
